/* design/tc_pkg.sv */
// Package for the triangle counter: sizes, queue item type, sequencer states
// and the effective vertex count helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tc_pkg;

  localparam int MAX_VERTICES = 128;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int NV_W         = $clog2(MAX_VERTICES + 1);
  localparam int VTX_W        = 7;
  localparam int CFG_W        = 8;
  localparam int COUNT_W      = 19;
  localparam logic [COUNT_W:0] COUNT_MAX = 20'd524287;
  localparam int CHUNK_W      = 16;
  localparam int CHUNKS       = (MAX_VERTICES + CHUNK_W - 1) / CHUNK_W;
  localparam int PART_W       = $clog2(CHUNK_W + 1);
  localparam int SUM_W        = $clog2(MAX_VERTICES + 1);
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam logic [CFG_W-1:0] VC_RESET = 8'd128;

  typedef struct packed {
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic              store;
    logic              last;
  } edge_t;

  typedef enum logic [2:0] {
    B_IDLE, B_EDGE_WR, B_ROW, B_LOAD, B_SCAN, B_DRAIN, B_OUT
  } bstate_t;

  function automatic logic [NV_W-1:0] eff_vertices(input logic [CFG_W-1:0] vc);
    int v;
    v = int'(vc);
    if (v > MAX_VERTICES) v = MAX_VERTICES;
    return NV_W'(v);
  endfunction

endpackage
`default_nettype wire

/* design/tc_front.sv */
// Front end: classifies each edge request and queues it for the back end.
// Depends on tc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tc_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [tc_pkg::VTX_W-1:0] first_vertex,
  input  wire logic [tc_pkg::VTX_W-1:0] second_vertex,
  input  wire logic                     last_edge,
  input  wire logic [tc_pkg::CFG_W-1:0] vc,
  output logic                          q_valid,
  output tc_pkg::edge_t                 q_item,
  input  wire logic                     q_pop
);

  tc_pkg::edge_t                 slots [tc_pkg::QDEPTH];
  logic [tc_pkg::QPTR_W-1:0]     wptr, rptr;
  logic [tc_pkg::QPTR_W:0]       fill;
  tc_pkg::edge_t                 item;
  logic [tc_pkg::NV_W-1:0]       n;
  logic                          do_push, do_pop;

  always_comb begin
    n          = tc_pkg::eff_vertices(vc);
    item.last  = last_edge;
    item.store = (first_vertex != second_vertex) &&
                 (tc_pkg::NV_W'(first_vertex) < n) && (tc_pkg::NV_W'(second_vertex) < n);
    if (first_vertex < second_vertex) begin
      item.lo = tc_pkg::ADDR_W'(first_vertex);
      item.hi = tc_pkg::ADDR_W'(second_vertex);
    end else begin
      item.lo = tc_pkg::ADDR_W'(second_vertex);
      item.hi = tc_pkg::ADDR_W'(first_vertex);
    end
  end

  assign full    = (fill == (tc_pkg::QPTR_W + 1)'(tc_pkg::QDEPTH));
  assign q_valid = (fill != '0);
  assign q_item  = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= item;
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      fill <= fill + (tc_pkg::QPTR_W + 1)'(do_push) - (tc_pkg::QPTR_W + 1)'(do_pop);
    end
  end

  property p_no_pop_empty;
    @(posedge clk) disable iff (rst) q_pop |-> q_valid;
  endproperty
  a_no_pop_empty: assert property (p_no_pop_empty) else $error("pop from empty queue");

  property p_fill_bound;
    @(posedge clk) disable iff (rst) fill <= (tc_pkg::QPTR_W + 1)'(tc_pkg::QDEPTH);
  endproperty
  a_fill_bound: assert property (p_fill_bound) else $error("queue overfilled");

  property p_full_hold;
    @(posedge clk) disable iff (rst) full && !q_pop |=> full;
  endproperty
  a_full_hold: assert property (p_full_hold) else $error("full dropped without a pop");

endmodule
`default_nettype wire

/* design/tc_back.sv */
// Back end: upper-triangle adjacency memory, edge update, counting pass and
// result register. Depends on tc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tc_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [tc_pkg::CFG_W-1:0]   vc,
  input  wire logic                       q_valid,
  input  wire tc_pkg::edge_t              q_item,
  output logic                            q_pop,
  output logic                            res_valid,
  output logic [tc_pkg::COUNT_W-1:0]      res_count,
  input  wire logic                       res_pop
);

  localparam int MV = tc_pkg::MAX_VERTICES;
  localparam int AW = tc_pkg::ADDR_W;

  // row r holds neighbors of r with a larger index
  logic [MV-1:0] mem [MV];
  logic [MV-1:0] vld;
  logic [MV-1:0] rd_q;
  logic          rd_vld_q;
  logic [MV-1:0] row_data;

  tc_pkg::bstate_t state, state_next;
  logic [AW-1:0]   ra, wa;
  logic            re, we, clr;
  logic [MV-1:0]   wd;

  logic [AW-1:0]   hi, hi_next, i, i_next, j, j_next;
  logic            last, last_next;
  logic [MV-1:0]   row_i;
  logic            load_row;
  logic [tc_pkg::NV_W-1:0] n;
  logic [MV-1:0]   nmask;

  logic            p1_valid, p2_valid, p3_valid;
  logic [AW-1:0]   p1_j;
  logic [tc_pkg::CHUNKS*tc_pkg::CHUNK_W-1:0] p2_vec;
  logic [tc_pkg::PART_W-1:0] p3_part [tc_pkg::CHUNKS];
  logic [tc_pkg::SUM_W-1:0]  sum;
  logic [tc_pkg::COUNT_W-1:0] total;
  logic [tc_pkg::COUNT_W:0]   total_sum;
  logic            clr_total, issue;

  assign n        = tc_pkg::eff_vertices(vc);
  assign row_data = rd_vld_q ? rd_q : '0;

  always_comb begin
    for (int k = 0; k < MV; k++) nmask[k] = (tc_pkg::NV_W'(k) < n);
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    re         = 1'b0;
    ra         = i;
    we         = 1'b0;
    wa         = i;
    wd         = row_data | (MV'(1) << hi);
    clr        = 1'b0;
    hi_next    = hi;
    last_next  = last;
    i_next     = i;
    j_next     = j;
    load_row   = 1'b0;
    issue      = 1'b0;
    clr_total  = 1'b0;
    case (state)
      tc_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          hi_next   = q_item.hi;
          last_next = q_item.last;
          i_next    = q_item.lo;
          if (q_item.store) begin
            re         = 1'b1;
            ra         = q_item.lo;
            state_next = tc_pkg::B_EDGE_WR;
          end else if (q_item.last) begin
            clr_total  = 1'b1;
            i_next     = '0;
            state_next = (n >= tc_pkg::NV_W'(3)) ? tc_pkg::B_ROW : tc_pkg::B_DRAIN;
          end
        end
      end
      tc_pkg::B_EDGE_WR: begin
        we = 1'b1;
        wa = i;
        if (last) begin
          clr_total  = 1'b1;
          i_next     = '0;
          state_next = (n >= tc_pkg::NV_W'(3)) ? tc_pkg::B_ROW : tc_pkg::B_DRAIN;
        end else begin
          state_next = tc_pkg::B_IDLE;
        end
      end
      tc_pkg::B_ROW: begin
        re         = 1'b1;
        ra         = i;
        state_next = tc_pkg::B_LOAD;
      end
      tc_pkg::B_LOAD: begin
        load_row   = 1'b1;
        j_next     = i + 1'b1;
        state_next = tc_pkg::B_SCAN;
      end
      tc_pkg::B_SCAN: begin
        re    = 1'b1;
        ra    = j;
        issue = 1'b1;
        if (tc_pkg::NV_W'(j) == n - 1'b1) begin
          if (tc_pkg::NV_W'(i) == n - tc_pkg::NV_W'(3)) begin
            state_next = tc_pkg::B_DRAIN;
          end else begin
            i_next     = i + 1'b1;
            state_next = tc_pkg::B_ROW;
          end
        end else begin
          j_next = j + 1'b1;
        end
      end
      tc_pkg::B_DRAIN: begin
        if (!p1_valid && !p2_valid && !p3_valid) state_next = tc_pkg::B_OUT;
      end
      tc_pkg::B_OUT: begin
        if (!res_valid) begin
          clr        = 1'b1;
          state_next = tc_pkg::B_IDLE;
        end
      end
      default: state_next = tc_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tc_pkg::B_IDLE;
    else     state <= state_next;
  end

  // memory and its valid bits
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (we) begin
      vld[wa] <= 1'b1;
    end
    if (re) rd_vld_q <= vld[ra];
  end

  always_ff @(posedge clk) begin
    hi   <= hi_next;
    last <= last_next;
    i    <= i_next;
    j    <= j_next;
    if (load_row) row_i <= row_data & nmask;
  end

  // scan pipeline: and rows, popcount in chunks, accumulate
  always_comb begin
    sum = '0;
    for (int c = 0; c < tc_pkg::CHUNKS; c++) sum = sum + tc_pkg::SUM_W'(p3_part[c]);
    total_sum = {1'b0, total} + (tc_pkg::COUNT_W + 1)'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
    end else begin
      p1_valid <= issue;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
    end
    p1_j   <= j;
    p2_vec <= (tc_pkg::CHUNKS*tc_pkg::CHUNK_W)'(row_i[p1_j] ? (row_i & row_data & nmask)
                                                              : '0);
    for (int c = 0; c < tc_pkg::CHUNKS; c++)
      p3_part[c] <= tc_pkg::PART_W'($countones(p2_vec[c*tc_pkg::CHUNK_W +: tc_pkg::CHUNK_W]));
    if (clr_total) begin
      total <= '0;
    end else if (p3_valid) begin
      total <= (total_sum > tc_pkg::COUNT_MAX) ? tc_pkg::COUNT_MAX[tc_pkg::COUNT_W-1:0]
                                               : total_sum[tc_pkg::COUNT_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (clr) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
    if (clr) res_count <= total;
  end

  property p_write_only_edge;
    @(posedge clk) disable iff (rst) we |-> (state == tc_pkg::B_EDGE_WR);
  endproperty
  a_write_only_edge: assert property (p_write_only_edge) else $error("matrix write outside edge");

  property p_res_hold;
    @(posedge clk) disable iff (rst) res_valid && !res_pop |=> res_valid && $stable(res_count);
  endproperty
  a_res_hold: assert property (p_res_hold) else $error("result lost before pop");

  property p_clear_after_out;
    @(posedge clk) disable iff (rst) clr |=> (vld == '0);
  endproperty
  a_clear_after_out: assert property (p_clear_after_out) else $error("matrix not cleared");

endmodule
`default_nettype wire

/* design/triangle_counter.sv */
// Top level of the triangle counter: configuration register, front end and
// back end. Depends on tc_pkg, tc_front and tc_back.
//
//  channel   handshake              payload
//  edge in   push / full            first_vertex, second_vertex, last_edge
//  count out empty / pop            triangle_count
//  config    cfg_we                 cfg_data (vertex_count)
//
// An edge request is a read-modify-write of one row of the single-port
// adjacency memory in the back end; ignored edges are popped without it.
// A counting pass reads one row per cycle while it scans a row, then
// drains the 3-stage pipeline and loads the result. The matrix clears
// through per-row valid bits, also at reset. A 4-entry queue holds edge
// requests during a pass; the count waits in an output register.
`timescale 1ns / 1ps
`default_nettype none
module triangle_counter (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [tc_pkg::VTX_W-1:0]   first_vertex,
  input  wire logic [tc_pkg::VTX_W-1:0]   second_vertex,
  input  wire logic                       last_edge,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [tc_pkg::COUNT_W-1:0]      triangle_count,
  input  wire logic                       cfg_we,
  input  wire logic [tc_pkg::CFG_W-1:0]   cfg_data
);

  logic [tc_pkg::CFG_W-1:0] vertex_count;
  logic                     q_valid, q_pop, res_valid;
  tc_pkg::edge_t            q_item;

  // hold the vertex count; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst)         vertex_count <= tc_pkg::VC_RESET;
    else if (cfg_we) vertex_count <= cfg_data;
  end

  tc_front u_front (
    .clk, .rst, .push, .full, .first_vertex, .second_vertex, .last_edge,
    .vc(vertex_count), .q_valid, .q_item, .q_pop
  );

  tc_back u_back (
    .clk, .rst, .vc(vertex_count), .q_valid, .q_item, .q_pop,
    .res_valid, .res_count(triangle_count), .res_pop(pop)
  );

  assign empty = !res_valid;

endmodule
`default_nettype wire

/* tb/tc_checker.sv */
// Checker for the triangle counter: watches the edge, count and config channels,
// predicts each triangle count and compares it. Depends on tc_pkg only.
`timescale 1ns / 1ps
module tc_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic                         full,
  input  logic [tc_pkg::VTX_W-1:0]     first_vertex,
  input  logic [tc_pkg::VTX_W-1:0]     second_vertex,
  input  logic                         last_edge,
  input  logic                         empty,
  input  logic                         pop,
  input  logic [tc_pkg::COUNT_W-1:0]   triangle_count,
  input  logic                         cfg_we,
  input  logic [tc_pkg::CFG_W-1:0]     cfg_data,
  output int                           errors,
  output int                           pending,
  output int                           counts_seen
);
  localparam int NV = tc_pkg::MAX_VERTICES;

  logic [NV-1:0]               adj_rows [NV];
  logic [tc_pkg::CFG_W-1:0]    vc_shadow;
  logic [tc_pkg::COUNT_W-1:0]  expected_counts [$];

  function automatic int live_vertices();
    return (int'(vc_shadow) > NV) ? NV : int'(vc_shadow);
  endfunction

  // Sum over adjacent pairs i<j of the common neighbours k>j below n.
  function automatic logic [tc_pkg::COUNT_W-1:0] tally_triangles(input int n);
    int              total;
    logic [NV-1:0]   live_mask;
    logic [NV-1:0]   above_mask;
    logic [NV-1:0]   one;
    total = 0;
    one = 1;
    live_mask = (n >= NV) ? '1 : ((one << n) - one);
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (adj_rows[i][j]) begin
          above_mask = live_mask & ~((one << (j + 1)) - one);
          total += $countones(adj_rows[i] & adj_rows[j] & above_mask);
          if (total > 524287) total = 524287;
        end
      end
    end
    return tc_pkg::COUNT_W'(total);
  endfunction

  always @(posedge clk) begin
    int n;
    logic [tc_pkg::COUNT_W-1:0] want;
    if (rst) begin
      for (int r = 0; r < NV; r++) adj_rows[r] = '0;
      vc_shadow = tc_pkg::VC_RESET;
      expected_counts.delete();
      errors = 0;
      counts_seen = 0;
    end else begin
      if (cfg_we) vc_shadow = cfg_data;
      if (push && !full) begin
        n = live_vertices();
        if (first_vertex != second_vertex && int'(first_vertex) < n &&
            int'(second_vertex) < n) begin
          adj_rows[first_vertex][second_vertex] = 1'b1;
          adj_rows[second_vertex][first_vertex] = 1'b1;
        end
        if (last_edge) begin
          expected_counts.push_back(tally_triangles(n));
          for (int r = 0; r < NV; r++) adj_rows[r] = '0;
        end
      end
      if (pop && !empty) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected count %0d", $time, triangle_count);
          errors++;
        end else begin
          want = expected_counts.pop_front();
          counts_seen++;
          if (triangle_count !== want) begin
            $display("%0t: triangle_count expected %0d actual %0d",
                     $time, want, triangle_count);
            errors++;
          end
        end
      end
    end
    pending = expected_counts.size();
  end
endmodule

/* tb/tb_triangle_counter.sv */
// Testbench top for the triangle counter: clock, reset, edge and config stimulus,
// count drain and verdict. Depends on tc_pkg, triangle_counter and tc_checker.
`timescale 1ns / 1ps
module tb_triangle_counter;

  logic                       clk;
  logic                       rst;
  logic                       push;
  logic                       full;
  logic [tc_pkg::VTX_W-1:0]   first_vertex;
  logic [tc_pkg::VTX_W-1:0]   second_vertex;
  logic                       last_edge;
  logic                       empty;
  logic                       pop;
  logic [tc_pkg::COUNT_W-1:0] triangle_count;
  logic                       cfg_we;
  logic [tc_pkg::CFG_W-1:0]   cfg_data;

  int errors;
  int pending;
  int counts_seen;
  int edges_sent;
  int graphs_sent;
  int big_graphs;
  bit calm;       // no idling on either side while set
  bit hold_req;   // ask the receiver for a long hold-off

  triangle_counter dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .first_vertex(first_vertex), .second_vertex(second_vertex),
    .last_edge(last_edge),
    .empty(empty), .pop(pop), .triangle_count(triangle_count),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  tc_checker chk (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .first_vertex(first_vertex), .second_vertex(second_vertex),
    .last_edge(last_edge),
    .empty(empty), .pop(pop), .triangle_count(triangle_count),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .counts_seen(counts_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: drop pop about 27% of the time, hold it low for a long
  // stretch on request so the block backs up and stalls its input.
  initial begin
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 400;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop = 1'b0;
      end else if (calm) begin
        pop = 1'b1;
      end else begin
        pop = ($urandom_range(99) >= 27);
      end
    end
  end

  // Offer one edge request; called and returns at a falling edge, push left high.
  task automatic send_edge(input logic [tc_pkg::VTX_W-1:0] a,
                           input logic [tc_pkg::VTX_W-1:0] b,
                           input bit fin);
    if (!calm && $urandom_range(99) < 27) begin
      push = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    push = 1'b1;
    first_vertex = a;
    second_vertex = b;
    last_edge = fin;
    do @(posedge clk); while (full);
    edges_sent++;
    if (fin) graphs_sent++;
    @(negedge clk);
  endtask

  // Let outstanding counts arrive and queued edges drain before touching the register.
  task automatic settle();
    push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_vertex_count(input logic [tc_pkg::CFG_W-1:0] v);
    settle();
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One random graph over n vertices: mostly in-range edges, some noise.
  task automatic send_graph(input int n, input int n_edges);
    logic [tc_pkg::VTX_W-1:0] a;
    logic [tc_pkg::VTX_W-1:0] b;
    for (int e = 0; e < n_edges; e++) begin
      if ($urandom_range(99) < 10 || n == 0) begin
        a = tc_pkg::VTX_W'($urandom_range(127));
        b = tc_pkg::VTX_W'($urandom_range(127));
      end else begin
        a = tc_pkg::VTX_W'($urandom_range(n - 1));
        b = (n > 1) ? tc_pkg::VTX_W'($urandom_range(n - 1)) : '0;
      end
      send_edge(a, b, e == n_edges - 1);
    end
  endtask

  initial begin
    int n;
    int iter;
    rst = 1'b1;
    push = 1'b0;
    first_vertex = '0;
    second_vertex = '0;
    last_edge = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    edges_sent = 0;
    graphs_sent = 0;
    big_graphs = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extreme vertices at the reset count, duplicates and a self-loop.
    send_edge(7'd0, 7'd127, 0);
    send_edge(7'd127, 7'd1, 0);
    send_edge(7'd1, 7'd0, 0);
    send_edge(7'd5, 7'd5, 0);
    send_edge(7'd0, 7'd127, 1);
    // Zero vertices: nothing stored, count is zero.
    write_vertex_count(8'd0);
    send_edge(7'd0, 7'd1, 0);
    send_edge(7'd1, 7'd2, 0);
    send_edge(7'd2, 7'd0, 1);
    // Saturated count: top vertices still usable.
    write_vertex_count(8'd255);
    send_edge(7'd127, 7'd126, 0);
    send_edge(7'd126, 7'd125, 0);
    send_edge(7'd125, 7'd127, 1);
    // Complete graph on four vertices plus an out-of-range endpoint.
    write_vertex_count(8'd4);
    send_edge(7'd0, 7'd1, 0);
    send_edge(7'd0, 7'd2, 0);
    send_edge(7'd0, 7'd3, 0);
    send_edge(7'd1, 7'd2, 0);
    send_edge(7'd1, 7'd3, 0);
    send_edge(7'd3, 7'd100, 0);
    send_edge(7'd2, 7'd3, 1);
    // Shrink the count mid-graph: the triangle on 3,4,5 drops out of the count.
    write_vertex_count(8'd6);
    send_edge(7'd4, 7'd5, 0);
    send_edge(7'd5, 7'd3, 0);
    send_edge(7'd3, 7'd4, 0);
    send_edge(7'd0, 7'd4, 0);
    send_edge(7'd1, 7'd4, 0);
    write_vertex_count(8'd5);
    send_edge(7'd0, 7'd1, 1);
    write_vertex_count(8'd1);
    send_edge(7'd0, 7'd0, 1);

    // Random graphs; a few at full size, most small and dense.
    iter = 0;
    while (edges_sent < 1175) begin
      calm = (iter >= 40 && iter < 60);
      if (iter % 4 == 0) begin
        if (big_graphs < 3 && iter % 20 == 8) begin
          n = ($urandom_range(1)) ? 128 : 255;
          big_graphs++;
        end else if ($urandom_range(9) == 0) begin
          n = $urandom_range(0, 2);
        end else begin
          n = $urandom_range(3, 16);
        end
        write_vertex_count(tc_pkg::CFG_W'(n));
      end
      n = (int'(cfg_data) > tc_pkg::MAX_VERTICES) ? tc_pkg::MAX_VERTICES : int'(cfg_data);
      if (iter == 10) begin
        // Back-pressure: hold the count while two more graphs pile in.
        hold_req = 1'b1;
        send_graph(n, 8);
        send_graph(n, 20);
      end else begin
        send_graph(n, (n >= 64) ? $urandom_range(20, 40) : $urandom_range(1, 20));
      end
      iter++;
    end

    settle();
    $display("Covered %0d edge requests in %0d graphs, %0d counts checked,",
             edges_sent, graphs_sent, counts_seen);
    $display("including %0d full-size graphs and a long output stall.", big_graphs);
    if (errors == 0) begin
      $display("[triangle_counter] OK");
    end else begin
      $display("[triangle_counter] ERROR");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("timeout waiting for counts");
    $display("[triangle_counter] ERROR");
    $finish;
  end
endmodule
